/* hw/rtl/ptld_pkg.sv */
// ----------------------------------------------------------------------------
// Point-to-line distance package
// Shared widths, payload types and the item type that the front part hands
// to the back part through the queue.
// ----------------------------------------------------------------------------
package ptld_pkg;

   // Coordinate format; the payload structs fix the coordinate width.
   localparam int COORD_WIDTH       = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIFF_WIDTH        = COORD_WIDTH + 1;
   localparam int DIST_WIDTH        = COORD_WIDTH + 1;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;

   // One request beat: point, line reference point and line direction.
   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type line_x;
      coord_type line_y;
      coord_type line_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } req_payload_type;

   // One response beat.
   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  zero_direction;
   } rsp_payload_type;

   // Classified item: the difference P - A, the direction and the zero flag.
   typedef struct packed {
      diff_type  [2:0] diff;
      coord_type [2:0] dir;
      logic            zero_dir;
   } ptld_item_type;

endpackage

/* hw/rtl/ptld_front.sv */
// ----------------------------------------------------------------------------
// Point-to-line distance front part
// Accepts request beats, forms the difference P - A and flags an all-zero
// direction, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module ptld_front
   import ptld_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   input  logic            queue_full,
   output logic            push_valid,
   output ptld_item_type   push_item
);

   logic          fr_valid_ff;
   logic          fr_valid_in;
   ptld_item_type fr_item_ff;
   ptld_item_type fr_item_in;
   logic          advance;

   // The front register holds only while the queue refuses its item.
   assign busy       = fr_valid_ff && queue_full;
   assign advance    = !busy;
   assign push_valid = fr_valid_ff && !queue_full;
   assign push_item  = fr_item_ff;

   // Classify the incoming beat.
   always_comb begin
      fr_valid_in = start;
      fr_item_in.diff[0] = DIFF_WIDTH'($signed(req_data.point_x))
                           - DIFF_WIDTH'($signed(req_data.line_x));
      fr_item_in.diff[1] = DIFF_WIDTH'($signed(req_data.point_y))
                           - DIFF_WIDTH'($signed(req_data.line_y));
      fr_item_in.diff[2] = DIFF_WIDTH'($signed(req_data.point_z))
                           - DIFF_WIDTH'($signed(req_data.line_z));
      fr_item_in.dir[0]  = req_data.dir_x;
      fr_item_in.dir[1]  = req_data.dir_y;
      fr_item_in.dir[2]  = req_data.dir_z;
      fr_item_in.zero_dir = (req_data.dir_x == '0) && (req_data.dir_y == '0)
                            && (req_data.dir_z == '0);
   end

   // Valid flag of the front register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else if (advance) begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   // Payload of the front register.
   always_ff @(posedge clock) begin
      if (advance) begin
         fr_item_ff <= fr_item_in;
      end
   end

endmodule

/* hw/rtl/ptld_queue.sv */
// ----------------------------------------------------------------------------
// Point-to-line distance queue
// A short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module ptld_queue
   import ptld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  ptld_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output ptld_item_type head_item
);

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   ptld_item_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]       wr_ptr_ff;
   logic [PTR_WIDTH-1:0]       wr_ptr_in;
   logic [PTR_WIDTH-1:0]       rd_ptr_ff;
   logic [PTR_WIDTH-1:0]       rd_ptr_in;
   logic [COUNT_WIDTH-1:0]     count_ff;
   logic [COUNT_WIDTH-1:0]     count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full       = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/ptld_back.sv */
// ----------------------------------------------------------------------------
// Point-to-line distance back part
// Pipeline that forms the projection quotient with a one-bit-per-stage
// divider, the residual vector, its squared length and a one-bit-per-stage
// square root.
// ----------------------------------------------------------------------------
module ptld_back
   import ptld_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  ptld_item_type   item,
   output logic            out_valid,
   output rsp_payload_type out_data
);

   localparam int W    = COORD_WIDTH;
   localparam int DW   = DIFF_WIDTH;
   localparam int NW   = 2 * W + 3;          // dot(D,d)
   localparam int DENW = 2 * W;              // dot(d,d)
   localparam int MAGW = NW + FRAC_BITS;     // scaled numerator magnitude
   localparam int EW   = W + FRAC_BITS + 2;  // residual component, signed
   localparam int EAW  = EW - 1;             // residual magnitude
   localparam int HT   = (EW + 1) / 2;       // split of the t*d product
   localparam int HE   = (EAW + 1) / 2;      // split of the square
   localparam int SW   = 2 * EAW;            // squared length
   localparam int RW   = EAW;                // root width

   // Stage 1: products of dot(D,d) and dot(d,d).
   logic                       mul_valid_ff;
   logic signed [DW+W-1:0]     mul_num_ff [3];
   logic signed [DW+W-1:0]     mul_num_in [3];
   logic signed [2*W-1:0]      mul_den_ff [3];
   logic signed [2*W-1:0]      mul_den_in [3];
   diff_type  [2:0]            mul_diff_ff;
   coord_type [2:0]            mul_dir_ff;
   logic                       mul_zero_ff;

   // Stage 2: the two dot products.
   logic                       sum_valid_ff;
   logic signed [NW-1:0]       sum_num_ff;
   logic signed [NW-1:0]       sum_num_in;
   logic [DENW-1:0]            sum_den_ff;
   logic [DENW-1:0]            sum_den_in;
   diff_type  [2:0]            sum_diff_ff;
   coord_type [2:0]            sum_dir_ff;
   logic                       sum_zero_ff;

   // Divider stages; entry 0 is loaded from stage 2.
   logic [MAGW:0]              dv_valid_ff;
   logic [DENW-1:0]            dv_rem_ff  [MAGW+1];
   logic [DENW-1:0]            dv_rem_in  [1:MAGW];
   logic [MAGW-1:0]            dv_nq_ff   [MAGW+1];
   logic [MAGW-1:0]            dv_nq_in   [1:MAGW];
   logic [DENW:0]              dv_trial   [1:MAGW];
   logic                       dv_ge      [1:MAGW];
   logic [DENW-1:0]            dv_den_ff  [MAGW+1];
   logic                       dv_neg_ff  [MAGW+1];
   logic                       dv_zero_ff [MAGW+1];
   diff_type  [2:0]            dv_diff_ff [MAGW+1];
   coord_type [2:0]            dv_dir_ff  [MAGW+1];
   logic [NW-1:0]              dv_mag;

   // Signed quotient, scaled difference and extended direction.
   logic                       tq_valid_ff;
   logic [EW-1:0]              tq_t_ff;
   logic [EW-1:0]              tq_t_in;
   logic [EW-1:0]              tq_qlow;
   logic [EW-1:0]              tq_base_ff [3];
   logic [EW-1:0]              tq_base_in [3];
   logic [EW-1:0]              tq_dext_ff [3];
   logic [EW-1:0]              tq_dext_in [3];
   logic                       tq_zero_ff;

   // Partial products of t*d.
   logic                       tp_valid_ff;
   logic [2*HT-1:0]            tp_ll_ff [3];
   logic [2*HT-1:0]            tp_ll_in [3];
   logic [EW-1:0]              tp_lh_ff [3];
   logic [EW-1:0]              tp_lh_in [3];
   logic [EW-1:0]              tp_hl_ff [3];
   logic [EW-1:0]              tp_hl_in [3];
   logic [EW-1:0]              tp_base_ff [3];
   logic                       tp_zero_ff;

   // Residual components and their magnitudes.
   logic                       rs_valid_ff;
   logic [EW-1:0]              rs_e_ff [3];
   logic [EW-1:0]              rs_e_in [3];
   logic                       rs_zero_ff;
   logic                       ab_valid_ff;
   logic [EAW-1:0]             ab_mag_ff [3];
   logic [EAW-1:0]             ab_mag_in [3];
   logic                       ab_zero_ff;

   // Partial products of the squares, then the squares.
   logic                       sp_valid_ff;
   logic [2*HE-1:0]            sp_ll_ff [3];
   logic [2*HE-1:0]            sp_ll_in [3];
   logic [EAW-1:0]             sp_lh_ff [3];
   logic [EAW-1:0]             sp_lh_in [3];
   logic [2*(EAW-HE)-1:0]      sp_hh_ff [3];
   logic [2*(EAW-HE)-1:0]      sp_hh_in [3];
   logic                       sp_zero_ff;
   logic                       sq_valid_ff;
   logic [SW-1:0]              sq_val_ff [3];
   logic [SW-1:0]              sq_val_in [3];
   logic                       sq_zero_ff;

   // Square root stages; entry 0 holds the squared length.
   logic [RW:0]                rt_valid_ff;
   logic [SW-1:0]              rt_x_ff    [RW+1];
   logic [SW-1:0]              rt_x_in    [1:RW];
   logic [RW:0]                rt_rem_ff  [RW+1];
   logic [RW:0]                rt_rem_in  [1:RW];
   logic [RW-1:0]              rt_root_ff [RW+1];
   logic [RW-1:0]              rt_root_in [1:RW];
   logic [RW+1:0]              rt_shift   [1:RW];
   logic [RW+1:0]              rt_trial   [1:RW];
   logic                       rt_ge      [1:RW];
   logic                       rt_zero_ff [RW+1];

   // Output register.
   logic                       out_valid_ff;
   rsp_payload_type            out_data_ff;

   // Valid flags of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         dv_valid_ff  <= '0;
         tq_valid_ff  <= 1'b0;
         tp_valid_ff  <= 1'b0;
         rs_valid_ff  <= 1'b0;
         ab_valid_ff  <= 1'b0;
         sp_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         rt_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= item_valid;
         sum_valid_ff <= mul_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[MAGW-1:0], sum_valid_ff};
         tq_valid_ff  <= dv_valid_ff[MAGW];
         tp_valid_ff  <= tq_valid_ff;
         rs_valid_ff  <= tp_valid_ff;
         ab_valid_ff  <= rs_valid_ff;
         sp_valid_ff  <= ab_valid_ff;
         sq_valid_ff  <= sp_valid_ff;
         rt_valid_ff  <= {rt_valid_ff[RW-1:0], sq_valid_ff};
         out_valid_ff <= rt_valid_ff[RW];
      end
   end

   // Stage 1 and 2 arithmetic: products, then dot products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul_num_in[i] = $signed(item.diff[i]) * $signed(item.dir[i]);
         mul_den_in[i] = $signed(item.dir[i]) * $signed(item.dir[i]);
      end
      sum_num_in = NW'(mul_num_ff[0]) + NW'(mul_num_ff[1]) + NW'(mul_num_ff[2]);
      sum_den_in = $unsigned(mul_den_ff[0]) + $unsigned(mul_den_ff[1])
                   + $unsigned(mul_den_ff[2]);
   end

   // Magnitude of the numerator and one quotient bit per divider stage.
   always_comb begin
      dv_mag = sum_num_ff[NW-1] ? NW'(-sum_num_ff) : NW'(sum_num_ff);
      for (int k = 1; k <= MAGW; k++) begin
         dv_trial[k]  = {dv_rem_ff[k-1], dv_nq_ff[k-1][MAGW-1]};
         dv_ge[k]     = (dv_trial[k] >= {1'b0, dv_den_ff[k-1]});
         dv_rem_in[k] = dv_ge[k] ? DENW'(dv_trial[k] - {1'b0, dv_den_ff[k-1]})
                                 : DENW'(dv_trial[k]);
         dv_nq_in[k]  = {dv_nq_ff[k-1][MAGW-2:0], dv_ge[k]};
      end
   end

   // Signed quotient modulo the residual width; a zero direction uses t = 0.
   always_comb begin
      tq_qlow = dv_nq_ff[MAGW][EW-1:0];
      if (dv_zero_ff[MAGW]) begin
         tq_t_in = '0;
      end else if (dv_neg_ff[MAGW]) begin
         tq_t_in = EW'(0) - tq_qlow;
      end else begin
         tq_t_in = tq_qlow;
      end
      for (int i = 0; i < 3; i++) begin
         tq_base_in[i] = {dv_diff_ff[MAGW][i][DW-1], dv_diff_ff[MAGW][i],
                          {FRAC_BITS{1'b0}}};
         tq_dext_in[i] = {{(EW-W){dv_dir_ff[MAGW][i][W-1]}}, dv_dir_ff[MAGW][i]};
      end
   end

   // Low part of t*d as three half-width products per component.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tp_ll_in[i] = tq_t_ff[HT-1:0] * tq_dext_ff[i][HT-1:0];
         tp_lh_in[i] = tq_t_ff[HT-1:0] * tq_dext_ff[i][EW-1:HT];
         tp_hl_in[i] = tq_t_ff[EW-1:HT] * tq_dext_ff[i][HT-1:0];
      end
   end

   // Residual D*2^F - t*d, exact within its width, and its magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rs_e_in[i] = tp_base_ff[i]
                      - (EW'(tp_ll_ff[i]) + ((tp_lh_ff[i] + tp_hl_ff[i]) << HT));
         ab_mag_in[i] = rs_e_ff[i][EW-1] ? EAW'(EW'(0) - rs_e_ff[i])
                                         : EAW'(rs_e_ff[i]);
      end
   end

   // Squares from half-width products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sp_ll_in[i] = ab_mag_ff[i][HE-1:0] * ab_mag_ff[i][HE-1:0];
         sp_lh_in[i] = ab_mag_ff[i][HE-1:0] * ab_mag_ff[i][EAW-1:HE];
         sp_hh_in[i] = ab_mag_ff[i][EAW-1:HE] * ab_mag_ff[i][EAW-1:HE];
         sq_val_in[i] = SW'(sp_ll_ff[i]) + (SW'(sp_lh_ff[i]) << (HE + 1))
                        + (SW'(sp_hh_ff[i]) << (2 * HE));
      end
   end

   // One root bit per square root stage.
   always_comb begin
      for (int k = 1; k <= RW; k++) begin
         rt_shift[k]   = {rt_rem_ff[k-1][RW-1:0], rt_x_ff[k-1][SW-1:SW-2]};
         rt_trial[k]   = {rt_root_ff[k-1], 2'b01};
         rt_ge[k]      = (rt_shift[k] >= rt_trial[k]);
         rt_rem_in[k]  = rt_ge[k] ? (RW+1)'(rt_shift[k] - rt_trial[k])
                                  : (RW+1)'(rt_shift[k]);
         rt_root_in[k] = {rt_root_ff[k-1][RW-2:0], rt_ge[k]};
         rt_x_in[k]    = {rt_x_ff[k-1][SW-3:0], 2'b00};
      end
   end

   // Payload registers of every stage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mul_num_ff[i] <= mul_num_in[i];
         mul_den_ff[i] <= mul_den_in[i];
         tq_base_ff[i] <= tq_base_in[i];
         tq_dext_ff[i] <= tq_dext_in[i];
         tp_ll_ff[i]   <= tp_ll_in[i];
         tp_lh_ff[i]   <= tp_lh_in[i];
         tp_hl_ff[i]   <= tp_hl_in[i];
         tp_base_ff[i] <= tq_base_ff[i];
         rs_e_ff[i]    <= rs_e_in[i];
         ab_mag_ff[i]  <= ab_mag_in[i];
         sp_ll_ff[i]   <= sp_ll_in[i];
         sp_lh_ff[i]   <= sp_lh_in[i];
         sp_hh_ff[i]   <= sp_hh_in[i];
         sq_val_ff[i]  <= sq_val_in[i];
      end
      mul_diff_ff <= item.diff;
      mul_dir_ff  <= item.dir;
      mul_zero_ff <= item.zero_dir;

      sum_num_ff  <= sum_num_in;
      sum_den_ff  <= sum_den_in;
      sum_diff_ff <= mul_diff_ff;
      sum_dir_ff  <= mul_dir_ff;
      sum_zero_ff <= mul_zero_ff;

      dv_rem_ff[0]  <= '0;
      dv_nq_ff[0]   <= {dv_mag, {FRAC_BITS{1'b0}}};
      dv_den_ff[0]  <= sum_den_ff;
      dv_neg_ff[0]  <= sum_num_ff[NW-1];
      dv_zero_ff[0] <= sum_zero_ff;
      dv_diff_ff[0] <= sum_diff_ff;
      dv_dir_ff[0]  <= sum_dir_ff;
      for (int k = 1; k <= MAGW; k++) begin
         dv_rem_ff[k]  <= dv_rem_in[k];
         dv_nq_ff[k]   <= dv_nq_in[k];
         dv_den_ff[k]  <= dv_den_ff[k-1];
         dv_neg_ff[k]  <= dv_neg_ff[k-1];
         dv_zero_ff[k] <= dv_zero_ff[k-1];
         dv_diff_ff[k] <= dv_diff_ff[k-1];
         dv_dir_ff[k]  <= dv_dir_ff[k-1];
      end

      tq_t_ff    <= tq_t_in;
      tq_zero_ff <= dv_zero_ff[MAGW];
      tp_zero_ff <= tq_zero_ff;
      rs_zero_ff <= tp_zero_ff;
      ab_zero_ff <= rs_zero_ff;
      sp_zero_ff <= ab_zero_ff;
      sq_zero_ff <= sp_zero_ff;

      rt_x_ff[0]    <= sq_val_ff[0] + sq_val_ff[1] + sq_val_ff[2];
      rt_rem_ff[0]  <= '0;
      rt_root_ff[0] <= '0;
      rt_zero_ff[0] <= sq_zero_ff;
      for (int k = 1; k <= RW; k++) begin
         rt_x_ff[k]    <= rt_x_in[k];
         rt_rem_ff[k]  <= rt_rem_in[k];
         rt_root_ff[k] <= rt_root_in[k];
         rt_zero_ff[k] <= rt_zero_ff[k-1];
      end

      out_data_ff.distance       <= rt_root_ff[RW][RW-1:FRAC_BITS];
      out_data_ff.zero_direction <= rt_zero_ff[RW];
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

/* hw/rtl/point_to_line_distance_3d_core.sv */
// ----------------------------------------------------------------------------
// Point-to-line distance in three dimensions
// Distance from a point to a line given by a point and a direction, all in
// signed fixed point, with the result floored to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a clock edge with start high and busy low.
//   req_data carries P, A and d. The front part forms P - A and flags an
//   all-zero direction; a two-entry queue hands the item to the back part.
//   The back part is a fixed pipeline: two dot-product stages, a restoring
//   divider with one quotient bit per stage (2*COORD_WIDTH+3+FRAC_BITS
//   stages), seven residual and square stages, and a square root with one
//   root bit per stage (COORD_WIDTH+FRAC_BITS+1 stages).
//   Throughput: one beat per cycle; the back part never stalls, so busy
//   stays low in operation.
//   Each response beat is on rsp_valid/rsp_data for exactly one cycle and
//   is not held; the receiver must take it then.
//   Reset clears all valid flags and the queue; items in flight are lost.
// ----------------------------------------------------------------------------
module point_to_line_distance_3d_core
   import ptld_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);

   logic          push_valid;
   ptld_item_type push_item;
   logic          queue_full;
   logic          head_valid;
   ptld_item_type head_item;

   // Front part: accept and classify.
   ptld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Queue between the two parts.
   ptld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (head_valid),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back part: the arithmetic pipeline takes the head every cycle.
   ptld_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .out_valid  (rsp_valid),
      .out_data   (rsp_data)
   );

endmodule

/* hw/rtl/ptld_checker.sv */
// ----------------------------------------------------------------------------
// Point-to-line distance checker
// Port-level assertions on timing and the zero-direction flag.
// ----------------------------------------------------------------------------
module ptld_checker
   import ptld_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input rsp_payload_type rsp_data
);

   localparam int LATENCY = (2 * COORD_WIDTH + 3 + FRAC_BITS)
                            + (COORD_WIDTH + FRAC_BITS + 1) + 13;

   // The back part drains every cycle, so the front never holds off.
   a_never_busy : assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised although the back part never stalls");

   // Every accepted beat yields a response after the fixed latency.
   a_response : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat produced no response");

   // No response appears without a matching accepted beat.
   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without an accepted beat");

   // The zero-direction flag follows the direction of the matching beat.
   a_zero_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.zero_direction == $past((req_data.dir_x == '0)
         && (req_data.dir_y == '0) && (req_data.dir_z == '0), LATENCY)))
      else $error("zero_direction does not match the request");

endmodule

bind point_to_line_distance_3d_core ptld_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
